// ===== sv/fcmc_pkg.sv =====
// ----------------------------------------------------------------------------
// fcmc_pkg
// Shared types and constants for the fifo replacement cache miss counter.
// ----------------------------------------------------------------------------
package fcmc_pkg;

  localparam int KEY_FIELD_W = 10;
  localparam int MISS_W      = 32;
  localparam int CAP_W       = 8;

  localparam int IN_TDATA_W  = ((KEY_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 1 + MISS_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [APB_ADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]      CAP_RESET    = 8'd100;

  typedef struct packed {
    logic shift;
    logic drop;
  } cell_ctl_t;

endpackage

// ===== sv/fcmc_cell.sv =====
// ----------------------------------------------------------------------------
// fcmc_cell
// One slot of the resident key chain. Holds one key with its valid bit,
// shifts toward the older end on an insert, and passes the lookup token
// to its neighbor one cell per cycle, folding in its own match.
// ----------------------------------------------------------------------------
module fcmc_cell
  import fcmc_pkg::*;
#(
  parameter int KEY_W = 10
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctl_t        ctl,
  input  logic [KEY_W-1:0] key_in,
  input  logic             valid_in,
  output logic [KEY_W-1:0] key,
  output logic             valid,
  input  logic             q_valid_in,
  input  logic [KEY_W-1:0] q_key_in,
  input  logic             q_hit_in,
  output logic             q_valid,
  output logic [KEY_W-1:0] q_key,
  output logic             q_hit
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      q_valid <= 1'b0;
    end else begin
      if (ctl.shift) begin
        valid <= valid_in & ~ctl.drop;
      end
      q_valid <= q_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key <= key_in;
    end
    q_key <= q_key_in;
    q_hit <= q_hit_in | (valid & (key == q_key_in));
  end

endmodule

// ===== sv/fifo_cache_miss_counter_core.sv =====
// ----------------------------------------------------------------------------
// fifo_cache_miss_counter_core
// Fully associative key cache with first-in-first-out replacement and a
// saturating miss counter. Resident keys live in a chain of cells ordered
// by age, newest in cell 0.
//
//   channel   dir  handshake          payload
//   s_axis    in   tvalid/tready      tdata: key
//   m_axis    out  tvalid/tready      tdata: hit, miss_count
//   apb       in   psel/penable/...   capacity at byte address 0
//
// each item passes the reduce, search and update states in turn; the lookup
// token walks the cell chain one cell per cycle, and a key at or beyond
// KEY_SPACE stays in reduce while KEY_SPACE is subtracted from it.
// a new item is taken while a finished result still waits on m_axis.
// rst is synchronous and empties the cache, clears the count and sets
// capacity to 100.
// ----------------------------------------------------------------------------
module fifo_cache_miss_counter_core
  import fcmc_pkg::*;
#(
  parameter int KEY_SPACE    = 1024,
  parameter int MAX_CAPACITY = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // hit, miss_count
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int KEY_W = (KEY_SPACE > 2) ? $clog2(KEY_SPACE) : 1;
  localparam int OCC_W = $clog2(MAX_CAPACITY + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]             state;
  logic [1:0]             state_next;
  logic [CAP_W-1:0]       capacity;
  logic [KEY_FIELD_W-1:0] red_key;
  logic                   hit_reg;
  logic [OCC_W-1:0]       occupancy;
  logic [MISS_W-1:0]      misses;
  logic [MISS_W-1:0]      misses_next;
  logic                   out_hit;
  logic [MISS_W-1:0]      out_miss;

  logic                   cfg_write;
  logic                   too_big;
  logic                   q_start;
  logic                   out_free;
  logic                   upd_go;
  logic                   insert;
  logic                   has_room;
  logic [OCC_W-1:0]       cap_eff;
  logic [KEY_W-1:0]       search_key;

  logic [KEY_W-1:0]       st_key   [MAX_CAPACITY];
  logic                   st_valid [MAX_CAPACITY];
  logic [KEY_W-1:0]       q_key    [MAX_CAPACITY];
  logic                   q_valid  [MAX_CAPACITY];
  logic                   q_hit    [MAX_CAPACITY];
  cell_ctl_t              ctl      [MAX_CAPACITY];

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready
                   & (paddr[APB_ADDR_W-1:2] == REG_CAPACITY);
  assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_CAPACITY)
                   ? APB_DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_write) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign cap_eff = (32'(capacity) > 32'(MAX_CAPACITY))
                 ? OCC_W'(MAX_CAPACITY) : OCC_W'(capacity);

  // control
  assign s_axis_tready = (state == ST_IDLE);
  assign too_big       = (32'(red_key) >= 32'(KEY_SPACE));
  assign q_start       = (state == ST_REDUCE) & ~too_big;
  assign search_key    = KEY_W'(red_key);
  assign out_free      = ~m_axis_tvalid | m_axis_tready;
  assign upd_go        = (state == ST_UPDATE) & out_free;
  assign has_room      = (occupancy < cap_eff);
  assign insert        = upd_go & ~hit_reg & (has_room | (occupancy != '0));
  assign misses_next   = (misses != '1) ? misses + MISS_W'(1) : misses;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) state_next = ST_REDUCE;
      end
      ST_REDUCE: begin
        if (!too_big) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (q_valid[MAX_CAPACITY-1]) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occupancy     <= '0;
      misses        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (upd_go && !hit_reg) begin
        misses <= misses_next;
        if (has_room) begin
          occupancy <= occupancy + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      red_key <= s_axis_tdata[KEY_FIELD_W-1:0];
    end else if (state == ST_REDUCE && too_big) begin
      red_key <= red_key - KEY_FIELD_W'(KEY_SPACE);
    end
    if (state == ST_SEARCH && q_valid[MAX_CAPACITY-1]) begin
      hit_reg <= q_hit[MAX_CAPACITY-1];
    end
    if (upd_go) begin
      out_hit  <= hit_reg;
      out_miss <= hit_reg ? misses : misses_next;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_miss, out_hit};

  // cell chain
  for (genvar i = 0; i < MAX_CAPACITY; i++) begin : g_cell
    assign ctl[i].shift = insert;
    assign ctl[i].drop  = insert & ~has_room & (occupancy == OCC_W'(i));

    if (i == 0) begin : g_head
      fcmc_cell #(
        .KEY_W (KEY_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl[i]),
        .key_in     (search_key),
        .valid_in   (1'b1),
        .key        (st_key[i]),
        .valid      (st_valid[i]),
        .q_valid_in (q_start),
        .q_key_in   (search_key),
        .q_hit_in   (1'b0),
        .q_valid    (q_valid[i]),
        .q_key      (q_key[i]),
        .q_hit      (q_hit[i])
      );
    end else begin : g_body
      fcmc_cell #(
        .KEY_W (KEY_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl[i]),
        .key_in     (st_key[i-1]),
        .valid_in   (st_valid[i-1]),
        .key        (st_key[i]),
        .valid      (st_valid[i]),
        .q_valid_in (q_valid[i-1]),
        .q_key_in   (q_key[i-1]),
        .q_hit_in   (q_hit[i-1]),
        .q_valid    (q_valid[i]),
        .q_key      (q_key[i]),
        .q_hit      (q_hit[i])
      );
    end
  end

endmodule
